FILE: design/sha_rct_pkg.sv
// ----------------------------------------------------------------------------
// sha_rct_pkg
// Shared types and constants of the reduced-width SHA-256 round with carry
// trace: beat layouts, item kind codes, round constant table.
// ----------------------------------------------------------------------------
package sha_rct_pkg;

    // Item kinds
    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_ROUND = 1'b1
    } kind_t;

    localparam int FIELD_BITS = 16;
    localparam int SLOT_BITS  = 3;
    localparam int RIDX_BITS  = 6;
    localparam int NUM_WORDS  = 8;
    localparam int NUM_ROUNDS = 64;

    // Working word slots
    localparam logic [SLOT_BITS-1:0] SLOT_A = 3'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_B = 3'd1;
    localparam logic [SLOT_BITS-1:0] SLOT_C = 3'd2;
    localparam logic [SLOT_BITS-1:0] SLOT_D = 3'd3;
    localparam logic [SLOT_BITS-1:0] SLOT_E = 3'd4;
    localparam logic [SLOT_BITS-1:0] SLOT_F = 3'd5;
    localparam logic [SLOT_BITS-1:0] SLOT_G = 3'd6;
    localparam logic [SLOT_BITS-1:0] SLOT_H = 3'd7;

    typedef struct packed {
        kind_t                 kind;
        logic [SLOT_BITS-1:0]  slot;
        logic [FIELD_BITS-1:0] word;
        logic [RIDX_BITS-1:0]  round_index;
    } req_beat_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] carry_h_sig1;
        logic [FIELD_BITS-1:0] carry_add_ch;
        logic [FIELD_BITS-1:0] carry_add_k;
        logic [FIELD_BITS-1:0] carry_add_w;
        logic [FIELD_BITS-1:0] carry_sig0_maj;
        logic [FIELD_BITS-1:0] carry_new_e;
        logic [FIELD_BITS-1:0] carry_new_a;
        logic [FIELD_BITS-1:0] next_a;
        logic [FIELD_BITS-1:0] next_e;
    } rsp_beat_t;

    localparam logic [31:0] ROUND_CONST [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Rotation amount k scaled to k*w/32, round half to even, at least 1.
    // Elaboration-time only.
    function automatic int scaled_rot(input int k, input int w);
        int num;
        int q;
        int r;
        num = k * w;
        q   = num / 32;
        r   = num % 32;
        if (r > 16 || (r == 16 && (q % 2) == 1)) begin
            q = q + 1;
        end
        if (q < 1) begin
            q = 1;
        end
        return q;
    endfunction

endpackage

FILE: design/sha_rct_if.sv
// ----------------------------------------------------------------------------
// sha_rct_if
// Valid/ready channels of the round block: request beats in, result beats out.
// ----------------------------------------------------------------------------
interface sha_rct_req_if;
    logic                   valid;
    logic                   ready;
    sha_rct_pkg::req_beat_t beat;

    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

interface sha_rct_rsp_if;
    logic                   valid;
    logic                   ready;
    sha_rct_pkg::rsp_beat_t beat;

    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

FILE: design/sha256_round_carry_trace_top.sv
// ----------------------------------------------------------------------------
// sha256_round_carry_trace_top
// One SHA-256 compression round at WORD_BITS width, reporting the carry-out
// vector of each of its seven modular additions plus the new a and e.
// ----------------------------------------------------------------------------
//
//  channel  dir  beat                    meaning
//  -------  ---  ----------------------  -------------------------------------
//  req      in   sha_rct_pkg::req_beat_t  load one working word, or run a round
//  rsp      out  sha_rct_pkg::rsp_beat_t  carry trace and new a/e of a round
//
//  A request beat lands in an input register; when it fires, one round of
//  logic runs on it and the working words, and a round beat lands in the
//  result register. One beat per cycle sustained while the result side does
//  not stall; five dependent adds (h+S1+Ch+K+W, then d+T1 / T1+T2) set the
//  clock period. Load beats update the working words and give no result.
//  Reset clears the working words and all valid flags. A stalled result
//  holds one round beat in the input register; a load beat there drains.
//
module sha256_round_carry_trace_top #(
    parameter int WORD_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    sha_rct_req_if.sink       req,
    sha_rct_rsp_if.source     rsp
);

    localparam int FB = sha_rct_pkg::FIELD_BITS;

    // Scaled rotation amounts, reduced modulo the width
    localparam int S0_R0 = sha_rct_pkg::scaled_rot(2, WORD_BITS) % WORD_BITS;
    localparam int S0_R1 = sha_rct_pkg::scaled_rot(13, WORD_BITS) % WORD_BITS;
    localparam int S0_R2 = sha_rct_pkg::scaled_rot(22, WORD_BITS) % WORD_BITS;
    localparam int S1_R0 = sha_rct_pkg::scaled_rot(6, WORD_BITS) % WORD_BITS;
    localparam int S1_R1 = sha_rct_pkg::scaled_rot(11, WORD_BITS) % WORD_BITS;
    localparam int S1_R2 = sha_rct_pkg::scaled_rot(25, WORD_BITS) % WORD_BITS;

    typedef logic [WORD_BITS-1:0] word_t;

    // 16-bit field to working width (truncate or zero-extend)
    function automatic word_t fit_word(input logic [FB-1:0] x);
        logic [WORD_BITS+FB-1:0] wide;
        wide = {{WORD_BITS{1'b0}}, x};
        return wide[WORD_BITS-1:0];
    endfunction

    // Working width to 16-bit field
    function automatic logic [FB-1:0] fit_field(input word_t x);
        logic [WORD_BITS+FB-1:0] wide;
        wide = {{FB{1'b0}}, x};
        return wide[FB-1:0];
    endfunction

    function automatic word_t rotr(input word_t x, input int k);
        logic [2*WORD_BITS-1:0] dbl;
        dbl = {x, x} >> k;
        return dbl[WORD_BITS-1:0];
    endfunction

    // Returns {carry vector, sum}; carry bit i is the carry out of bit i
    function automatic logic [2*WORD_BITS-1:0] add_trace(input word_t x, input word_t y);
        logic [WORD_BITS:0] s;
        logic [WORD_BITS:0] cin;
        s   = {1'b0, x} + {1'b0, y};
        cin = {1'b0, x} ^ {1'b0, y} ^ s;
        return {cin[WORD_BITS:1], s[WORD_BITS-1:0]};
    endfunction

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                   s1_valid_reg;
    sha_rct_pkg::req_beat_t s1_beat_reg;
    logic                   s1_fire;
    logic                   s1_round;

    // Result register
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    sha_rct_pkg::rsp_beat_t rsp_beat_reg;
    sha_rct_pkg::rsp_beat_t rsp_beat_next;

    // Working words a..h
    word_t words_reg [sha_rct_pkg::NUM_WORDS];

    assign s1_round = (s1_beat_reg.kind == sha_rct_pkg::KIND_ROUND);
    // Loads never need the result register; rounds need it free or draining
    assign s1_fire  = s1_valid_reg && (!s1_round || !rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_beat_reg <= req.beat;
        end
    end

    // ------------------------------------------------------------------
    // Round logic
    // ------------------------------------------------------------------
    word_t a, b, c, d, e, f, g, h;
    word_t k_word, w_word;
    word_t sig0, sig1, ch, mj;
    logic [2*WORD_BITS-1:0] r_t0, r_t1, r_t2, r_t1f, r_t2f, r_ne, r_na;

    assign a = words_reg[sha_rct_pkg::SLOT_A];
    assign b = words_reg[sha_rct_pkg::SLOT_B];
    assign c = words_reg[sha_rct_pkg::SLOT_C];
    assign d = words_reg[sha_rct_pkg::SLOT_D];
    assign e = words_reg[sha_rct_pkg::SLOT_E];
    assign f = words_reg[sha_rct_pkg::SLOT_F];
    assign g = words_reg[sha_rct_pkg::SLOT_G];
    assign h = words_reg[sha_rct_pkg::SLOT_H];

    assign w_word = fit_word(s1_beat_reg.word);
    assign k_word = sha_rct_pkg::ROUND_CONST[s1_beat_reg.round_index][WORD_BITS-1:0];

    assign sig0 = rotr(a, S0_R0) ^ rotr(a, S0_R1) ^ rotr(a, S0_R2);
    assign sig1 = rotr(e, S1_R0) ^ rotr(e, S1_R1) ^ rotr(e, S1_R2);
    assign ch   = (e & f) ^ (~e & g);
    assign mj   = (a & b) ^ (a & c) ^ (b & c);

    // Low half of each result is the sum, high half the carry vector
    assign r_t0  = add_trace(h, sig1);
    assign r_t1  = add_trace(r_t0[WORD_BITS-1:0], ch);
    assign r_t2  = add_trace(r_t1[WORD_BITS-1:0], k_word);
    assign r_t1f = add_trace(r_t2[WORD_BITS-1:0], w_word);
    assign r_t2f = add_trace(sig0, mj);
    assign r_ne  = add_trace(d, r_t1f[WORD_BITS-1:0]);
    assign r_na  = add_trace(r_t1f[WORD_BITS-1:0], r_t2f[WORD_BITS-1:0]);

    always_comb
    begin
        rsp_beat_next.carry_h_sig1   = fit_field(r_t0[2*WORD_BITS-1:WORD_BITS]);
        rsp_beat_next.carry_add_ch   = fit_field(r_t1[2*WORD_BITS-1:WORD_BITS]);
        rsp_beat_next.carry_add_k    = fit_field(r_t2[2*WORD_BITS-1:WORD_BITS]);
        rsp_beat_next.carry_add_w    = fit_field(r_t1f[2*WORD_BITS-1:WORD_BITS]);
        rsp_beat_next.carry_sig0_maj = fit_field(r_t2f[2*WORD_BITS-1:WORD_BITS]);
        rsp_beat_next.carry_new_e    = fit_field(r_ne[2*WORD_BITS-1:WORD_BITS]);
        rsp_beat_next.carry_new_a    = fit_field(r_na[2*WORD_BITS-1:WORD_BITS]);
        rsp_beat_next.next_a         = fit_field(r_na[WORD_BITS-1:0]);
        rsp_beat_next.next_e         = fit_field(r_ne[WORD_BITS-1:0]);
    end

    // Working word update: load writes one slot, round shifts the row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sha_rct_pkg::NUM_WORDS; i++)
            begin
                words_reg[i] <= '0;
            end
        end
        else if (s1_fire)
        begin
            if (s1_round)
            begin
                words_reg[sha_rct_pkg::SLOT_A] <= r_na[WORD_BITS-1:0];
                words_reg[sha_rct_pkg::SLOT_B] <= a;
                words_reg[sha_rct_pkg::SLOT_C] <= b;
                words_reg[sha_rct_pkg::SLOT_D] <= c;
                words_reg[sha_rct_pkg::SLOT_E] <= r_ne[WORD_BITS-1:0];
                words_reg[sha_rct_pkg::SLOT_F] <= e;
                words_reg[sha_rct_pkg::SLOT_G] <= f;
                words_reg[sha_rct_pkg::SLOT_H] <= g;
            end
            else
            begin
                words_reg[s1_beat_reg.slot] <= w_word;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        if (s1_fire && s1_round)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_round)
        begin
            rsp_beat_reg <= rsp_beat_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.beat  = rsp_beat_reg;

`ifndef SYNTHESIS
    a_round_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_round |=> rsp.valid)
        else $error("round finished without a result beat");

    a_load_writes_slot: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && !s1_round |=>
            words_reg[$past(s1_beat_reg.slot)] == $past(w_word))
        else $error("load did not write its slot");

    a_round_shifts: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_round |=>
            words_reg[sha_rct_pkg::SLOT_B] == $past(a) &&
            words_reg[sha_rct_pkg::SLOT_F] == $past(e))
        else $error("working words not shifted by round");

    a_next_a_matches: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_round |=>
            rsp.beat.next_a == fit_field(words_reg[sha_rct_pkg::SLOT_A]) &&
            rsp.beat.next_e == fit_field(words_reg[sha_rct_pkg::SLOT_E]))
        else $error("reported a/e differ from stored a/e");

    a_stall_only_on_round: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |-> s1_round && rsp_valid_reg && !rsp.ready)
        else $error("input register stalled without cause");
`endif

endmodule

FILE: bench/sha256_round_carry_trace_top_test.sv
// ----------------------------------------------------------------------------
// sha256_round_carry_trace_top_test
// Self-checking bench for the reduced-width SHA-256 round with carry trace.
// A shadow copy of the eight working words predicts every round beat: the
// carry-out vector of each of the seven adds plus the new a and e. Directed
// extremes come first, then random load/round sequences under three
// valid/ready idle mixes and one long result stall.
// ----------------------------------------------------------------------------
module sha256_round_carry_trace_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Word width under test; the port fields are FIELD_BITS wide.
    localparam int WB = 16;
    // Cycles with no beat on either channel before the run is declared hung.
    // Well above the longest deliberate result stall below.
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    // Cycles to wait once no result is outstanding, before the final verdict.
    localparam int TAIL_CYCLES = 10;

    typedef logic [sha_rct_pkg::SLOT_BITS-1:0]  slot_t;
    typedef logic [sha_rct_pkg::RIDX_BITS-1:0]  ridx_t;
    typedef logic [sha_rct_pkg::FIELD_BITS-1:0] field_t;

    logic clk;
    logic rst_n;

    sha_rct_req_if req_if ();
    sha_rct_rsp_if rsp_if ();

    sha256_round_carry_trace_top #(
        .WORD_BITS(WB)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .rsp  (rsp_if)
    );

    // Shadow state and bookkeeping
    logic [WB-1:0]          shadow_words [sha_rct_pkg::NUM_WORDS];
    sha_rct_pkg::rsp_beat_t pending_traces [$];
    int                     fault_count    = 0;
    int                     loads_seen     = 0;
    int                     rounds_checked = 0;
    int                     quiet_cycles   = 0;
    int                     send_idle_pct  = 0;
    int                     recv_idle_pct  = 0;
    int                     hold_left      = 0;
    logic [63:0]            ridx_seen      = '0;
    logic [7:0]             slots_loaded   = '0;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Round arithmetic at width WB
    // ------------------------------------------------------------------

    // Rotation k of the 32-bit round scaled by WB/32, ties to even, floor 1.
    function automatic int rot_steps(input int k);
        int whole;
        int frac;
        whole = (k * WB) / 32;
        frac  = (k * WB) % 32;
        if (frac > 16 || (frac == 16 && whole[0]))
        begin
            whole++;
        end
        return (whole == 0) ? 1 : whole;
    endfunction

    function automatic logic [WB-1:0] rotr_w(input logic [WB-1:0] x, input int n);
        int amt;
        amt = n % WB;
        if (amt == 0)
        begin
            return x;
        end
        return (x >> amt) | (x << (WB - amt));
    endfunction

    // Sum mod 2^WB; carries[i] is the carry out of bit i.
    function automatic logic [WB-1:0] add_with_carries(input logic [WB-1:0] x,
                                                       input logic [WB-1:0] y,
                                                       output logic [WB-1:0] carries);
        logic [WB:0] full;
        logic [WB:0] cin;
        full    = {1'b0, x} + {1'b0, y};
        cin     = {1'b0, x} ^ {1'b0, y} ^ full;
        carries = cin[WB:1];
        return full[WB-1:0];
    endfunction

    // Applies one accepted request beat to the shadow words. A round beat
    // also queues the trace the block must return for it.
    function automatic void apply_beat(input sha_rct_pkg::req_beat_t item);
        logic [WB-1:0] wa, wb, wc, wd, we, wf, wg, wh;
        logic [WB-1:0] k_masked, ch, mj, s0, s1;
        logic [WB-1:0] part0, part1, part2, t1, t2, new_a, new_e;
        logic [WB-1:0] cy [7];
        sha_rct_pkg::rsp_beat_t trace;
        if (item.kind == sha_rct_pkg::KIND_LOAD)
        begin
            shadow_words[item.slot] = item.word[WB-1:0];
            slots_loaded[item.slot] = 1'b1;
            loads_seen++;
            return;
        end
        wa = shadow_words[sha_rct_pkg::SLOT_A];
        wb = shadow_words[sha_rct_pkg::SLOT_B];
        wc = shadow_words[sha_rct_pkg::SLOT_C];
        wd = shadow_words[sha_rct_pkg::SLOT_D];
        we = shadow_words[sha_rct_pkg::SLOT_E];
        wf = shadow_words[sha_rct_pkg::SLOT_F];
        wg = shadow_words[sha_rct_pkg::SLOT_G];
        wh = shadow_words[sha_rct_pkg::SLOT_H];
        k_masked = sha_rct_pkg::ROUND_CONST[item.round_index][WB-1:0];

        ch = (we & wf) ^ (~we & wg);
        mj = (wa & wb) ^ (wa & wc) ^ (wb & wc);
        s1 = rotr_w(we, rot_steps(6)) ^ rotr_w(we, rot_steps(11)) ^ rotr_w(we, rot_steps(25));
        s0 = rotr_w(wa, rot_steps(2)) ^ rotr_w(wa, rot_steps(13)) ^ rotr_w(wa, rot_steps(22));

        part0 = add_with_carries(wh, s1, cy[0]);
        part1 = add_with_carries(part0, ch, cy[1]);
        part2 = add_with_carries(part1, k_masked, cy[2]);
        t1    = add_with_carries(part2, item.word[WB-1:0], cy[3]);
        t2    = add_with_carries(s0, mj, cy[4]);
        new_e = add_with_carries(wd, t1, cy[5]);
        new_a = add_with_carries(t1, t2, cy[6]);

        shadow_words[sha_rct_pkg::SLOT_H] = wg;
        shadow_words[sha_rct_pkg::SLOT_G] = wf;
        shadow_words[sha_rct_pkg::SLOT_F] = we;
        shadow_words[sha_rct_pkg::SLOT_E] = new_e;
        shadow_words[sha_rct_pkg::SLOT_D] = wc;
        shadow_words[sha_rct_pkg::SLOT_C] = wb;
        shadow_words[sha_rct_pkg::SLOT_B] = wa;
        shadow_words[sha_rct_pkg::SLOT_A] = new_a;

        trace.carry_h_sig1   = cy[0];
        trace.carry_add_ch   = cy[1];
        trace.carry_add_k    = cy[2];
        trace.carry_add_w    = cy[3];
        trace.carry_sig0_maj = cy[4];
        trace.carry_new_e    = cy[5];
        trace.carry_new_a    = cy[6];
        trace.next_a         = new_a;
        trace.next_e         = new_e;
        pending_traces.push_back(trace);
        ridx_seen[item.round_index] = 1'b1;
    endfunction

    function automatic void check_field(input string name,
                                        input field_t want,
                                        input field_t got);
        if (got !== want)
        begin
            fault_count++;
            $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
        end
    endfunction

    function automatic void compare_trace(input sha_rct_pkg::rsp_beat_t want,
                                          input sha_rct_pkg::rsp_beat_t got);
        check_field("carry_h_sig1",   want.carry_h_sig1,   got.carry_h_sig1);
        check_field("carry_add_ch",   want.carry_add_ch,   got.carry_add_ch);
        check_field("carry_add_k",    want.carry_add_k,    got.carry_add_k);
        check_field("carry_add_w",    want.carry_add_w,    got.carry_add_w);
        check_field("carry_sig0_maj", want.carry_sig0_maj, got.carry_sig0_maj);
        check_field("carry_new_e",    want.carry_new_e,    got.carry_new_e);
        check_field("carry_new_a",    want.carry_new_a,    got.carry_new_a);
        check_field("next_a",         want.next_a,         got.next_a);
        check_field("next_e",         want.next_e,         got.next_e);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sampled at the rising edge. The result beat is checked
    // before the request beat of the same edge is applied; a result comes
    // from a registered request, never from the one accepted with it.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sha_rct_pkg::rsp_beat_t got;
        sha_rct_pkg::rsp_beat_t want;
        logic                   moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (rsp_if.valid && rsp_if.ready)
            begin
                moved = 1'b1;
                got   = rsp_if.beat;
                if (pending_traces.size() == 0)
                begin
                    fault_count++;
                    $display("%0t unexpected result beat, expected none actual %h",
                             $time, got);
                end
                else
                begin
                    want = pending_traces.pop_front();
                    compare_trace(want, got);
                    rounds_checked++;
                end
            end
            if (req_if.valid && req_if.ready)
            begin
                moved = 1'b1;
                apply_beat(req_if.beat);
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a long run of cycles without any beat means a hang.
    // ------------------------------------------------------------------
    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
        end
        $display("%0t no beat moved for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, pending_traces.size());
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: ready changes at the falling edge. A requested hold-off
    // is counted down here, one cycle per falling edge, independently of
    // the sender, which keeps offering beats meanwhile.
    // ------------------------------------------------------------------
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side. Called at a falling edge, returns at a falling edge with
    // valid still high; the next call or end_requests decides its next value,
    // so valid is assigned once per step.
    // ------------------------------------------------------------------
    task automatic send_beat(input sha_rct_pkg::req_beat_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.beat  <= item;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic end_requests();
        req_if.valid <= 1'b0;
    endtask

    // Unused fields of a beat carry random bits so every input bit toggles.
    task automatic send_load(input slot_t slot, input field_t value);
        sha_rct_pkg::req_beat_t item;
        item             = '0;
        item.kind        = sha_rct_pkg::KIND_LOAD;
        item.slot        = slot;
        item.word        = value;
        item.round_index = ridx_t'($urandom);
        send_beat(item);
    endtask

    task automatic send_round(input field_t msg, input ridx_t ridx);
        sha_rct_pkg::req_beat_t item;
        item             = '0;
        item.kind        = sha_rct_pkg::KIND_ROUND;
        item.slot        = slot_t'($urandom);
        item.word        = msg;
        item.round_index = ridx;
        send_beat(item);
    endtask

    // Random word with extra weight on the corners of the carry chain.
    function automatic field_t pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(sha_rct_pkg::FIELD_BITS-1){1'b0}}};
            3:       return {{(sha_rct_pkg::FIELD_BITS-1){1'b0}}, 1'b1};
            default: return field_t'($urandom);
        endcase
    endfunction

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes: round on the all-zero reset state, all-ones state with an
    // all-ones message, alternating top bits, first and last round constants,
    // back-to-back rounds.
    task automatic test_directed();
        int s;
        send_round('0, 6'd0);
        for (s = 0; s < sha_rct_pkg::NUM_WORDS; s++)
        begin
            send_load(slot_t'(s), '1);
        end
        send_round('1, 6'd63);
        for (s = 0; s < sha_rct_pkg::NUM_WORDS; s++)
        begin
            send_load(slot_t'(s), s[0] ? 16'h7fff : 16'h8000);
        end
        send_round(16'h8000, 6'd56);
        send_round(16'h0001, 6'd57);
        send_load(sha_rct_pkg::SLOT_H, '0);
        send_round('0, 6'd63);
    endtask

    // Mostly well-formed: some loads with random content, then a run of
    // rounds; the rest is random kind mixes.
    task automatic test_random_sequences(input int n_items);
        int sent;
        int i;
        int n_load;
        int n_round;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) < 7)
            begin
                n_load  = $urandom_range(8);
                n_round = $urandom_range(1, 6);
                for (i = 0; i < n_load; i++)
                begin
                    send_load(slot_t'($urandom), pick_word());
                end
                for (i = 0; i < n_round; i++)
                begin
                    send_round(pick_word(), ridx_t'($urandom));
                end
                sent += n_load + n_round;
            end
            else
            begin
                n_load = $urandom_range(1, 5);
                for (i = 0; i < n_load; i++)
                begin
                    if ($urandom_range(1))
                    begin
                        send_round(pick_word(), ridx_t'($urandom));
                    end
                    else
                    begin
                        send_load(slot_t'($urandom), pick_word());
                    end
                end
                sent += n_load;
            end
        end
    endtask

    // Result side frozen for a long stretch while rounds and loads keep
    // coming: the pipeline fills and the request side must stall.
    task automatic test_result_stall();
        int i;
        hold_left = HOLD_CYCLES;
        for (i = 0; i < 24; i++)
        begin
            if ($urandom_range(3) == 0)
            begin
                send_load(slot_t'($urandom), pick_word());
            end
            else
            begin
                send_round(pick_word(), ridx_t'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int s;
        for (s = 0; s < sha_rct_pkg::NUM_WORDS; s++)
        begin
            shadow_words[s] = '0;
        end
        req_if.valid = 1'b0;
        req_if.beat  = '0;
        rst_n        = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Phase 1: sender idles lightly, receiver heavily
        set_idle(35, 70);
        test_directed();
        test_random_sequences(400);

        // Phase 2: roles swapped, plus the long result stall
        set_idle(70, 35);
        test_random_sequences(400);
        test_result_stall();

        // Phase 3: full throughput
        set_idle(0, 0);
        test_random_sequences(330);
        end_requests();

        while (pending_traces.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d load beats and %0d checked round beats, %0d faults.",
                 loads_seen, rounds_checked, fault_count);
        $display("Round indexes used: %0d of 64; working slots loaded: %0d of 8.",
                 $countones(ridx_seen), $countones(slots_loaded));
        if (fault_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
design/sha_rct_pkg.sv
design/sha_rct_if.sv
design/sha256_round_carry_trace_top.sv
bench/sha256_round_carry_trace_top_test.sv
